// File: hdl/pmsm_pkg.sv
// Package for the pooled mean/deviation merge block.
// Holds the request and result structs and the datapath widths.
// No dependencies.
package pmsm_pkg;

  localparam int DATA_W  = 32;
  localparam int MCAND_W = 65;                 // largest multiplicand: std^2 + offset^2
  localparam int MPLR_W  = 32;                 // multiplier operand, one bit per cycle
  localparam int PROD_W  = MCAND_W + MPLR_W;   // 97-bit product
  localparam int NUM_W   = PROD_W + 1;         // sum of two products
  localparam int DEN_W   = DATA_W + 1;         // exact count sum
  localparam int RAD_W   = 2 * DATA_W;         // square root radicand

  typedef struct packed {
    logic                     start_req;
    logic signed [DATA_W-1:0] in_mean;
    logic [DATA_W-1:0]        in_std;
    logic [DATA_W-1:0]        in_count;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_mean;
    logic [DATA_W-1:0]        out_std;
    logic [DATA_W-1:0]        out_count;
    logic                     count_overflow;
  } rsp_t;

endpackage

// File: hdl/pmsm_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pmsm_pkg for the operand and product widths.
module pmsm_mul import pmsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MCAND_W-1:0] a,
  input  logic [MPLR_W-1:0]  b,
  output logic               done,
  output logic [PROD_W-1:0]  p
);

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mc;
  logic [MPLR_W-1:0] mb;
  logic [5:0]        cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        mc   <= {{MPLR_W{1'b0}}, a};
        mb   <= b;
        cnt  <= 6'(MPLR_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (mb[0]) begin
          acc <= acc + mc;
        end
        mc  <= {mc[PROD_W-2:0], 1'b0};
        mb  <= {1'b0, mb[MPLR_W-1:1]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc;

endmodule

// File: hdl/pmsm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pmsm_pkg for the dividend and divisor widths.
module pmsm_div import pmsm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] d;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   r2;
  logic             ge;
  logic [6:0]       cnt;
  logic             busy;

  assign r2 = {rem, sh[NUM_W-1]};
  assign ge = r2 >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= num;
        d    <= den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= 7'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        // The partial remainder stays below the divisor, so it fits DEN_W bits.
        rem <= ge ? DEN_W'(r2 - {1'b0, d}) : r2[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        sh  <= {sh[NUM_W-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/pmsm_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on pmsm_pkg for the radicand width.
module pmsm_sqrt import pmsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  v,
  output logic              done,
  output logic [DATA_W-1:0] root
);

  logic [RAD_W-1:0]  sh;
  logic [DATA_W+1:0] rem;
  logic [DATA_W+3:0] r2;
  logic [DATA_W+3:0] trial;
  logic              ge;
  logic [5:0]        cnt;
  logic              busy;

  assign r2    = {rem, sh[RAD_W-1:RAD_W-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= v;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'(DATA_W);
        busy <= 1'b1;
      end else if (busy) begin
        // The remainder never exceeds twice the root, so it fits DATA_W+2 bits.
        rem  <= ge ? (DATA_W+2)'(r2 - trial) : r2[DATA_W+1:0];
        root <= {root[DATA_W-2:0], ge};
        sh   <= {sh[RAD_W-3:0], 2'b00};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/pooled_mean_std_merge.sv
// Top level of the pooled mean/deviation merge block: sequencer and running record.
// Depends on pmsm_pkg, pmsm_mul, pmsm_div and pmsm_sqrt.
//
//   Channel  Valid      Stall      Payload   Direction
//   request  src_valid  src_stall  src_data  into the block
//   result   dst_valid  dst_stall  dst_data  out of the block
//
// A start request goes straight to the finishing state. A merge request with a nonzero
// count sum runs eight passes of the bit-serial multiplier, two passes of the bit-serial
// divider and, unless the variance quotient is out of range, one square root pass.
// The serial units produce one bit per cycle.
// Reset clears the running record to zero and empties the result register.
// The result register lets a new request be taken while the last result waits;
// a stalled result only delays the end of the following request.
module pooled_mean_std_merge import pmsm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  req_t src_data,
  output logic dst_valid,
  input  logic dst_stall,
  output rsp_t dst_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ZCHK  = 4'd1;
  localparam logic [3:0] S_MB1   = 4'd2;
  localparam logic [3:0] S_MB2   = 4'd3;
  localparam logic [3:0] S_DMEAN = 4'd4;
  localparam logic [3:0] S_S1    = 4'd5;
  localparam logic [3:0] S_A1    = 4'd6;
  localparam logic [3:0] S_T1    = 4'd7;
  localparam logic [3:0] S_S2    = 4'd8;
  localparam logic [3:0] S_A2    = 4'd9;
  localparam logic [3:0] S_T2    = 4'd10;
  localparam logic [3:0] S_DVAR  = 4'd11;
  localparam logic [3:0] S_SQRT  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};

  logic [3:0]        st;
  logic              launched;
  req_t              inp;
  logic [DATA_W-1:0] run_mean;
  logic [DATA_W-1:0] run_std;
  logic [DATA_W-1:0] run_count;
  logic [DEN_W-1:0]  total;
  logic [NUM_W-1:0]  sum;
  logic [MCAND_W-1:0] t;
  rsp_t              res;

  // Offsets of both parts from the new mean, as magnitudes.
  logic [DATA_W:0]   d1, d2, a1_full, a2_full;
  logic [DATA_W-1:0] a1, a2;

  assign d1 = {run_mean[DATA_W-1], run_mean} - {res.out_mean[DATA_W-1], res.out_mean};
  assign d2 = {inp.in_mean[DATA_W-1], inp.in_mean}
            - {res.out_mean[DATA_W-1], res.out_mean};
  assign a1_full = d1[DATA_W] ? ((DATA_W+1)'(0) - d1) : d1;
  assign a2_full = d2[DATA_W] ? ((DATA_W+1)'(0) - d2) : d2;
  assign a1 = a1_full[DATA_W-1:0];
  assign a2 = a2_full[DATA_W-1:0];

  // Unit hookup. Only one unit runs at a time; the state picks its operands.
  logic               mul_start, mul_done, div_start, div_done, sq_start, sq_done;
  logic [MCAND_W-1:0] mul_a;
  logic [MPLR_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [NUM_W-1:0]   quo;
  logic [DATA_W-1:0]  root;
  logic               in_mul;

  assign in_mul = st inside {S_MB1, S_MB2, S_S1, S_A1, S_T1, S_S2, S_A2, S_T2};
  assign mul_start = in_mul && !launched;
  assign div_start = (st == S_DMEAN || st == S_DVAR) && !launched;
  assign sq_start  = (st == S_SQRT) && !launched;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_MB1: begin
        mul_a = MCAND_W'(run_mean ^ SIGN_BIT);
        mul_b = run_count;
      end
      S_MB2: begin
        mul_a = MCAND_W'(inp.in_mean ^ SIGN_BIT);
        mul_b = inp.in_count;
      end
      S_S1: begin
        mul_a = MCAND_W'(run_std);
        mul_b = run_std;
      end
      S_A1: begin
        mul_a = MCAND_W'(a1);
        mul_b = a1;
      end
      S_T1: begin
        mul_a = t;
        mul_b = run_count;
      end
      S_S2: begin
        mul_a = MCAND_W'(inp.in_std);
        mul_b = inp.in_std;
      end
      S_A2: begin
        mul_a = MCAND_W'(a2);
        mul_b = a2;
      end
      S_T2: begin
        mul_a = t;
        mul_b = inp.in_count;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pmsm_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  pmsm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum), .den(total),
    .done(div_done), .quo(quo)
  );

  pmsm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .v(sum[RAD_W-1:0]),
    .done(sq_done), .root(root)
  );

  assign src_stall = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      launched  <= 1'b0;
      run_mean  <= '0;
      run_std   <= '0;
      run_count <= '0;
      dst_valid <= 1'b0;
    end else begin
      // In the finishing state the result register is refilled below instead.
      if (dst_valid && !dst_stall && st != S_FIN) begin
        dst_valid <= 1'b0;
      end
      if (mul_start || div_start || sq_start) begin
        launched <= 1'b1;
      end
      case (st)
        S_IDLE: begin
          if (src_valid) begin
            inp   <= src_data;
            total <= {1'b0, run_count} + {1'b0, src_data.in_count};
            if (src_data.start_req) begin
              res.out_mean       <= src_data.in_mean;
              res.out_std        <= src_data.in_std;
              res.out_count      <= src_data.in_count;
              res.count_overflow <= 1'b0;
              st <= S_FIN;
            end else begin
              st <= S_ZCHK;
            end
          end
        end
        S_ZCHK: begin
          if (total == '0) begin
            res <= '0;
            st  <= S_FIN;
          end else begin
            // Only the emitted count saturates; the arithmetic uses the exact sum.
            res.out_count      <= total[DATA_W] ? '1 : total[DATA_W-1:0];
            res.count_overflow <= total[DATA_W];
            st <= S_MB1;
          end
        end
        S_MB1, S_MB2, S_T1, S_T2: begin
          if (mul_done) begin
            launched <= 1'b0;
            if (st == S_MB1 || st == S_T1) begin
              sum <= NUM_W'(mul_p);
            end else begin
              sum <= sum + NUM_W'(mul_p);
            end
            case (st)
              S_MB1:   st <= S_MB2;
              S_MB2:   st <= S_DMEAN;
              S_T1:    st <= S_S2;
              default: st <= S_DVAR;
            endcase
          end
        end
        S_S1, S_A1, S_S2, S_A2: begin
          if (mul_done) begin
            launched <= 1'b0;
            if (st == S_S1 || st == S_S2) begin
              t <= mul_p[MCAND_W-1:0];
            end else begin
              t <= t + mul_p[MCAND_W-1:0];
            end
            case (st)
              S_S1:    st <= S_A1;
              S_A1:    st <= S_T1;
              S_S2:    st <= S_A2;
              default: st <= S_T2;
            endcase
          end
        end
        S_DMEAN: begin
          if (div_done) begin
            launched     <= 1'b0;
            // Means were biased to unsigned before weighting; undo the bias.
            res.out_mean <= quo[DATA_W-1:0] ^ SIGN_BIT;
            st <= S_S1;
          end
        end
        S_DVAR: begin
          if (div_done) begin
            launched <= 1'b0;
            if (quo[NUM_W-1:RAD_W] != '0) begin
              res.out_std <= '1;
              st <= S_FIN;
            end else begin
              sum <= quo;
              st  <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            launched    <= 1'b0;
            res.out_std <= root;
            st <= S_FIN;
          end
        end
        S_FIN: begin
          if (!dst_valid || !dst_stall) begin
            dst_data  <= res;
            dst_valid <= 1'b1;
            run_mean  <= res.out_mean;
            run_std   <= res.out_std;
            run_count <= res.out_count;
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/pmsm_chk.sv
// Port-level checker for the pooled mean/deviation merge block, bound to its top level.
// Depends on pmsm_pkg and pooled_mean_std_merge.
module pmsm_chk import pmsm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic src_valid,
  input logic src_stall,
  input req_t src_data,
  input logic dst_valid,
  input logic dst_stall,
  input rsp_t dst_data
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("stalled result changed");

  // A saturated count is flagged only together with the maximum count.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.count_overflow |-> dst_data.out_count == '1)
    else $error("overflow flag without saturated count");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall |=> src_stall)
    else $error("second request taken while busy");

  // Reset empties the result register.
  a_rst: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid after reset");

endmodule

bind pooled_mean_std_merge pmsm_chk u_pmsm_chk (.*);

// File: dv/pooled_mean_std_merge_tb.sv
// Self-checking testbench for pooled_mean_std_merge: directed table then random folds.
// Depends on pmsm_pkg and the block's RTL; results are checked against an internal predictor or typed-in values.
`timescale 1ns / 1ps

module pooled_mean_std_merge_tb;
  import pmsm_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    req_t req;
    bit   known;   // result typed in below instead of predicted
    rsp_t rsp;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  req_t src_data = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  rsp_t dst_data;

  // Running record of the predictor, mirrors the block's state.
  logic [31:0] pred_mean, pred_std, pred_count;

  rsp_t expected_results[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   saturations = 0;
  int   merges_sent = 0;
  bit   stall_quiet = 1'b0;
  int   stall_hold = 0;

  pooled_mean_std_merge dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generous hard stop: well beyond a slow run with long gaps and stalls.
  initial begin
    #400ms;
    $display("Timeout with %0d results still outstanding", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // Integer square root, rounded down.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[31:0];
  endfunction

  // count * (std^2 + (mean - centre)^2), exact.
  function automatic logic [127:0] spread_term(input logic [31:0] mean, input logic [31:0] std,
                                               input logic [31:0] count,
                                               input logic signed [63:0] centre);
    logic signed [63:0] d;
    logic [127:0] a, s, t;
    d = 64'(signed'(mean)) - centre;
    a = (d < 0) ? 128'(-d) : 128'(d);
    s = 128'(std);
    t = s * s + a * a;
    return t * 128'(count);
  endfunction

  // Applies one request to the predicted running record and returns the result.
  function automatic rsp_t fold_record(input req_t r);
    rsp_t o;
    logic [32:0]  total;
    logic [127:0] weighted, quot, spread;
    logic [31:0]  new_mean;
    o = '0;
    if (r.start_req) begin
      pred_mean  = r.in_mean;
      pred_std   = r.in_std;
      pred_count = r.in_count;
    end else begin
      total = 33'(pred_count) + 33'(r.in_count);
      if (total == 0) begin
        pred_mean = '0; pred_std = '0; pred_count = '0;
      end else begin
        // Offset-binary means make the weighted sum unsigned, so division floors.
        weighted = 128'(pred_mean ^ 32'h8000_0000) * 128'(pred_count)
                 + 128'(r.in_mean ^ 32'h8000_0000) * 128'(r.in_count);
        quot = weighted / 128'(total);
        new_mean = quot[31:0] ^ 32'h8000_0000;
        spread = (spread_term(pred_mean, pred_std, pred_count, 64'(signed'(new_mean)))
                + spread_term(r.in_mean, r.in_std, r.in_count, 64'(signed'(new_mean))))
                / 128'(total);
        pred_std  = (spread[127:64] != 0) ? 32'hFFFF_FFFF : floor_sqrt(spread[63:0]);
        pred_mean = new_mean;
        if (total[32]) begin
          pred_count = 32'hFFFF_FFFF;
          o.count_overflow = 1'b1;
        end else begin
          pred_count = total[31:0];
        end
      end
    end
    o.out_mean  = pred_mean;
    o.out_std   = pred_std;
    o.out_count = pred_count;
    return o;
  endfunction

  // Result side: mostly short random stalls, now and then a long one, and quiet
  // stretches where no new stall starts.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (stall_quiet) begin
      dst_stall <= 1'b0;
    end else if ($urandom_range(0, 1999) == 0) begin
      dst_stall  <= 1'b1;
      stall_hold <= $urandom_range(50, 400);
    end else if ($urandom_range(0, 99) < 40) begin
      dst_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(200, 3000)) @(posedge clk);
      stall_quiet = ~stall_quiet;
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && dst_valid && !dst_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("Unexpected result mean=%h std=%h count=%h ovf=%b",
                   dst_data.out_mean, dst_data.out_std, dst_data.out_count,
                   dst_data.count_overflow);
      end else begin
        want = expected_results.pop_front();
        if (want.count_overflow) saturations++;
        if (dst_data.out_mean !== want.out_mean || dst_data.out_std !== want.out_std ||
            dst_data.out_count !== want.out_count ||
            dst_data.count_overflow !== want.count_overflow) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Mismatch #%0d: expected mean=%h std=%h count=%h ovf=%b, ",
                     mismatches, want.out_mean, want.out_std, want.out_count,
                     want.count_overflow,
                     "got mean=%h std=%h count=%h ovf=%b",
                     dst_data.out_mean, dst_data.out_std,
                     dst_data.out_count, dst_data.count_overflow);
        end
      end
    end
  end

  // Gap after a request: mostly none or short, a few long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 8);
    return $urandom_range(50, 600);
  endfunction

  // Drives one request, holds it until taken, then records what it should produce.
  task automatic send_request(input req_t r, input bit known, input rsp_t typed);
    rsp_t predicted;
    int gap;
    src_valid <= 1'b1;
    src_data  <= r;
    do @(posedge clk); while (src_stall);
    predicted = fold_record(r);
    if (!r.start_req) merges_sent++;
    expected_results.insert(expected_results.size(), known ? typed : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_count();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(1, 50);
    if (p < 80) return $urandom_range(0, 65535);
    if (p < 90) return $urandom;
    if (p < 95) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return 32'd0;
  endfunction

  function automatic logic [31:0] rand_mean();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    if (p < 90) return $urandom;
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic logic [31:0] rand_std();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return $urandom_range(0, 1000000);
    if (p < 92) return $urandom;
    return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  step_row_t steps[$];

  function automatic step_row_t row(input bit st, input logic [31:0] m, input logic [31:0] s,
                                    input logic [31:0] n, input bit known,
                                    input logic [31:0] em, input logic [31:0] es,
                                    input logic [31:0] en, input bit eo);
    step_row_t x;
    x.req   = '{start_req: st, in_mean: m, in_std: s, in_count: n};
    x.known = known;
    x.rsp   = '{out_mean: em, out_std: es, out_count: en, count_overflow: eo};
    return x;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_step(input step_row_t x);
    steps.insert(steps.size(), x);
  endfunction

  initial begin
    req_t r;
    int left, burst;
    // Directed steps. A merge into the reset record with zero count gives all zeros;
    // a start request echoes its record with no overflow flag.
    add_step(row(0, 32'h0001_0000, 32'h0002_0000, 0, 1, 0, 0, 0, 0));
    add_step(row(0, 32'h0003_0000, 32'h0001_0000, 4, 0, 0, 0, 0, 0));
    add_step(row(0, 32'hFFFD_0000, 32'h0001_0000, 4, 0, 0, 0, 0, 0));
    add_step(row(1, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    // Count sum above the maximum: saturates and raises the flag.
    add_step(row(0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    add_step(row(0, 32'h0, 32'h0, 32'd1, 0, 0, 0, 0, 0));
    add_step(row(1, 32'h7FFF_FFFF, 32'h0, 0, 1, 32'h7FFF_FFFF, 0, 0, 0));
    // Zero count on both sides after a zero-count start.
    add_step(row(0, 32'h1234_5678, 32'h9ABC_DEF0, 0, 1, 0, 0, 0, 0));
    // Deviation too large: extreme means and deviations, one sample each.
    add_step(row(1, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1,
                 32'h8000_0000, 32'hFFFF_FFFF, 1, 0));
    add_step(row(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0));
    // Negative means: the weighted mean rounds toward minus infinity.
    add_step(row(1, 32'hFFFF_FFFF, 32'h0, 1, 1, 32'hFFFF_FFFF, 0, 1, 0));
    add_step(row(0, 32'hFFFF_FFFE, 32'h0, 1, 0, 0, 0, 0, 0));
    add_step(row(0, 32'h0000_0001, 32'h0000_8000, 3, 0, 0, 0, 0, 0));
    add_step(row(1, 32'h0000_0000, 32'h0001_0000, 10, 1, 0, 32'h0001_0000, 10, 0));
    add_step(row(0, 32'h0000_0000, 32'h0001_0000, 10, 0, 0, 0, 0, 0));
    add_step(row(0, 32'h0002_0000, 32'h0, 20, 0, 0, 0, 0, 0));
    add_step(row(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0));
    add_step(row(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0));

    pred_mean = '0; pred_std = '0; pred_count = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) send_request(steps[i].req, steps[i].known, steps[i].rsp);
    // Let the block empty completely before the random folds begin.
    drain_results();

    // Random folds: mostly a start followed by a burst of merges, some noise.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        r.start_req = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0);
        if ($urandom_range(0, 19) == 0) begin
          r.in_mean = $urandom; r.in_std = $urandom; r.in_count = $urandom;
        end else begin
          r.in_mean = rand_mean(); r.in_std = rand_std(); r.in_count = rand_count();
        end
        send_request(r, 1'b0, '0);
        left--;
      end
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    drain_results();
    repeat (600) @(posedge clk);
    $display("Covered %0d results, %0d merge requests, %0d count saturations.",
             results_seen, merges_sent, saturations);
    $display("Mismatches counted: %0d", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
